[rtl/core/linear_extended_state_observer_unit_macros.svh]
// Assertion macros for the observer unit.
// Used by linear_extended_state_observer_unit.sv; needs i_clk and i_rst_n in scope.
`ifndef LINEAR_EXTENDED_STATE_OBSERVER_UNIT_MACROS_SVH
`define LINEAR_EXTENDED_STATE_OBSERVER_UNIT_MACROS_SVH

// same-cycle implication
`define LESO_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define LESO_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[rtl/core/leso_pkg.sv]
// Types, widths and register indexes for the observer unit.
// No dependencies.
`timescale 1ns / 1ps

package leso_pkg;

    localparam int SIG_W   = 32;   // Q16.F signals
    localparam int ST_W    = 48;   // Q32.F states and intermediates
    localparam int SUM_W   = 50;   // room for three-term sums
    localparam int H_BITS  = 24;   // h fractional bits
    localparam int CHUNK_W = 16;   // multiplier slice of operand b
    localparam int PROD_W  = 96;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 47;

    localparam logic [IDX_W-1:0] CFG_ORDER = 3'd0;
    localparam logic [IDX_W-1:0] CFG_H     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_B0    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_BETA1 = 3'd3;
    localparam logic [IDX_W-1:0] CFG_BETA2 = 3'd4;
    localparam logic [IDX_W-1:0] CFG_BETA3 = 3'd5;
    localparam logic [IDX_W-1:0] CFG_ULIM  = 3'd6;

    localparam logic [1:0] ORDER_ONE = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        O1_B0, O1_G1, O1_Z1H, O1_G2, O1_Z2H, O1_DIV,
        O2_Z3G, O2_Z3H, O2_DIV, O2_Z2G, O2_Z2B, O2_Z2H, O2_Z1G, O2_Z1H,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {OPA_E, OPA_T, OPA_U, OPA_U0, OPA_ACC} t_opa;
    typedef enum logic [2:0] {OPB_B1, OPB_B2, OPB_B3, OPB_H, OPB_B0} t_opb;

    // saturate a wide sum to the 48-bit state range
    function automatic logic [ST_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(48'sh7FFF_FFFF_FFFF);
        lo = -SUM_W'(48'sh7FFF_FFFF_FFFF) - SUM_W'(1);
        if (v > hi)      sat_sum = 48'h7FFF_FFFF_FFFF;
        else if (v < lo) sat_sum = 48'h8000_0000_0000;
        else             sat_sum = v[ST_W-1:0];
    endfunction

endpackage

[rtl/core/linear_extended_state_observer_unit.sv]
// Top level of the fixed-point extended state observer (orders one and two).
// Depends on leso_pkg and linear_extended_state_observer_unit_macros.svh.
`timescale 1ns / 1ps
`include "linear_extended_state_observer_unit_macros.svh"

// One sample at a time. Every product goes through one shared 48x16 multiplier,
// in three 16-bit slices and then a saturating step; the quotient z/b0 goes through
// a restoring divider at one bit a cycle. o_in_stall is high while a sample is in
// work; a finished word waits in the output register while the next sample is taken.
module linear_extended_state_observer_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [leso_pkg::SIG_W-1:0] i_measured_y,
    input  logic signed [leso_pkg::SIG_W-1:0] i_nominal_u0,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [leso_pkg::SIG_W-1:0] o_control_u,
    output logic signed [leso_pkg::ST_W-1:0]  o_est_z1,
    output logic signed [leso_pkg::ST_W-1:0]  o_est_z2,
    output logic signed [leso_pkg::ST_W-1:0]  o_est_z3,
    output logic                             o_clamped,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [leso_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [leso_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int SW       = leso_pkg::ST_W;
    localparam int NUM_W    = SW + FRAC_BITS;
    localparam int CNT_W    = $clog2(NUM_W + 2);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W + 1);

    // configuration
    logic [1:0]  r_order;
    logic [23:0] r_h;
    logic [30:0] r_b0;
    logic [46:0] r_beta1, r_beta2, r_beta3;
    logic [30:0] r_ulim;

    // sequencer and datapath
    leso_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0]    r_z1, r_z2, r_z3;
    logic [SW-1:0]    r_e, r_t, r_u;
    logic [leso_pkg::SIG_W-1:0] r_u0;
    logic signed [leso_pkg::SUM_W-1:0] r_acc;
    logic [leso_pkg::PROD_W-1:0] r_prod;
    logic [NUM_W-1:0] r_quo;
    logic [30:0]      r_rem;
    logic             r_out_valid;

    logic c_is_mul, c_is_div, c_sh24, c_done;
    leso_pkg::t_opa c_opa;
    leso_pkg::t_opb c_opb;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != leso_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    // ---------------- config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 2'd2;
            r_h     <= 24'd16777;
            r_b0    <= 31'd65536;
            r_beta1 <= '0;
            r_beta2 <= '0;
            r_beta3 <= '0;
            r_ulim  <= 31'h7FFF_FFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                leso_pkg::CFG_ORDER: r_order <= i_cfg_data[1:0];
                leso_pkg::CFG_H:     r_h     <= i_cfg_data[23:0];
                leso_pkg::CFG_B0:    r_b0    <= i_cfg_data[30:0];
                leso_pkg::CFG_BETA1: r_beta1 <= i_cfg_data;
                leso_pkg::CFG_BETA2: r_beta2 <= i_cfg_data;
                leso_pkg::CFG_BETA3: r_beta3 <= i_cfg_data;
                leso_pkg::CFG_ULIM:  r_ulim  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- control decode
    always_comb begin
        c_is_mul = 1'b1;
        c_is_div = 1'b0;
        c_sh24   = 1'b0;
        c_opa    = leso_pkg::OPA_E;
        c_opb    = leso_pkg::OPB_B1;
        case (r_state)
            leso_pkg::O1_B0:  begin c_opa = leso_pkg::OPA_U0; c_opb = leso_pkg::OPB_B0; end
            leso_pkg::O1_G1:  begin c_opa = leso_pkg::OPA_E;  c_opb = leso_pkg::OPB_B1; end
            leso_pkg::O1_Z1H: begin
                c_opa = leso_pkg::OPA_ACC; c_opb = leso_pkg::OPB_H; c_sh24 = 1'b1;
            end
            leso_pkg::O1_G2:  begin c_opa = leso_pkg::OPA_E;  c_opb = leso_pkg::OPB_B2; end
            leso_pkg::O1_Z2H: begin
                c_opa = leso_pkg::OPA_T; c_opb = leso_pkg::OPB_H; c_sh24 = 1'b1;
            end
            leso_pkg::O2_Z3G: begin c_opa = leso_pkg::OPA_E;  c_opb = leso_pkg::OPB_B3; end
            leso_pkg::O2_Z3H: begin
                c_opa = leso_pkg::OPA_T; c_opb = leso_pkg::OPB_H; c_sh24 = 1'b1;
            end
            leso_pkg::O2_Z2G: begin c_opa = leso_pkg::OPA_E;  c_opb = leso_pkg::OPB_B2; end
            leso_pkg::O2_Z2B: begin c_opa = leso_pkg::OPA_U;  c_opb = leso_pkg::OPB_B0; end
            leso_pkg::O2_Z2H: begin
                c_opa = leso_pkg::OPA_ACC; c_opb = leso_pkg::OPB_H; c_sh24 = 1'b1;
            end
            leso_pkg::O2_Z1G: begin c_opa = leso_pkg::OPA_E;  c_opb = leso_pkg::OPB_B1; end
            leso_pkg::O2_Z1H: begin
                c_opa = leso_pkg::OPA_ACC; c_opb = leso_pkg::OPB_H; c_sh24 = 1'b1;
            end
            leso_pkg::O1_DIV, leso_pkg::O2_DIV: begin
                c_is_mul = 1'b0;
                c_is_div = 1'b1;
            end
            default: c_is_mul = 1'b0;
        endcase
    end

    assign c_done = (c_is_mul && r_cnt == MUL_LAST) || (c_is_div && r_cnt == DIV_LAST);

    // ---------------- next state
    always_comb begin
        n_state = r_state;
        n_cnt   = c_done ? '0 : ((c_is_mul || c_is_div) ? r_cnt + CNT_W'(1) : '0);
        case (r_state)
            leso_pkg::ST_IDLE:
                if (i_in_valid)
                    n_state = (r_order == leso_pkg::ORDER_ONE) ? leso_pkg::O1_B0
                                                               : leso_pkg::O2_Z3G;
            leso_pkg::O1_B0:  if (c_done) n_state = leso_pkg::O1_G1;
            leso_pkg::O1_G1:  if (c_done) n_state = leso_pkg::O1_Z1H;
            leso_pkg::O1_Z1H: if (c_done) n_state = leso_pkg::O1_G2;
            leso_pkg::O1_G2:  if (c_done) n_state = leso_pkg::O1_Z2H;
            leso_pkg::O1_Z2H: if (c_done) n_state = leso_pkg::O1_DIV;
            leso_pkg::O1_DIV: if (c_done) n_state = leso_pkg::ST_FIN;
            leso_pkg::O2_Z3G: if (c_done) n_state = leso_pkg::O2_Z3H;
            leso_pkg::O2_Z3H: if (c_done) n_state = leso_pkg::O2_DIV;
            leso_pkg::O2_DIV: if (c_done) n_state = leso_pkg::O2_Z2G;
            leso_pkg::O2_Z2G: if (c_done) n_state = leso_pkg::O2_Z2B;
            leso_pkg::O2_Z2B: if (c_done) n_state = leso_pkg::O2_Z2H;
            leso_pkg::O2_Z2H: if (c_done) n_state = leso_pkg::O2_Z1G;
            leso_pkg::O2_Z1G: if (c_done) n_state = leso_pkg::O2_Z1H;
            leso_pkg::O2_Z1H: if (c_done) n_state = leso_pkg::ST_FIN;
            leso_pkg::ST_FIN:
                if (!r_out_valid || !i_out_stall) n_state = leso_pkg::ST_IDLE;
            default: n_state = leso_pkg::ST_IDLE;
        endcase
    end

    // ---------------- shared multiplier operands
    logic [SW-1:0] a_val, a_mag;
    logic [SW-1:0] b_val;
    logic [leso_pkg::CHUNK_W-1:0] b_chunk;
    logic [SW+leso_pkg::CHUNK_W-1:0] partial;
    logic [leso_pkg::PROD_W-1:0] part_sh, prod_sh;
    logic [SW-1:0] m_res;
    logic          m_big;

    always_comb begin
        case (c_opa)
            leso_pkg::OPA_E:   a_val = r_e;
            leso_pkg::OPA_T:   a_val = r_t;
            leso_pkg::OPA_U:   a_val = r_u;
            leso_pkg::OPA_U0:  a_val = SW'($signed(r_u0));
            leso_pkg::OPA_ACC: a_val = leso_pkg::sat_sum(r_acc);
            default:           a_val = r_e;
        endcase
        case (c_opb)
            leso_pkg::OPB_B1: b_val = {1'b0, r_beta1};
            leso_pkg::OPB_B2: b_val = {1'b0, r_beta2};
            leso_pkg::OPB_B3: b_val = {1'b0, r_beta3};
            leso_pkg::OPB_H:  b_val = SW'(r_h);
            leso_pkg::OPB_B0: b_val = SW'(r_b0);
            default:          b_val = '0;
        endcase
        a_mag = a_val[SW-1] ? (~a_val + SW'(1)) : a_val;
        case (r_cnt[1:0])
            2'd0:    b_chunk = b_val[15:0];
            2'd1:    b_chunk = b_val[31:16];
            default: b_chunk = b_val[47:32];
        endcase
        partial = a_mag * b_chunk;
        case (r_cnt[1:0])
            2'd0:    part_sh = leso_pkg::PROD_W'(partial);
            2'd1:    part_sh = leso_pkg::PROD_W'(partial) << 16;
            default: part_sh = leso_pkg::PROD_W'(partial) << 32;
        endcase
        // truncate toward zero on the magnitude, then saturate and apply sign
        prod_sh = c_sh24 ? (r_prod >> leso_pkg::H_BITS) : (r_prod >> FRAC_BITS);
        m_big   = (|prod_sh[leso_pkg::PROD_W-1:SW]) ||
                  (a_val[SW-1] ? (prod_sh[SW-1:0] > 48'h8000_0000_0000)
                               : prod_sh[SW-1]);
        if (m_big)
            m_res = a_val[SW-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        else
            m_res = a_val[SW-1] ? (~prod_sh[SW-1:0] + SW'(1)) : prod_sh[SW-1:0];
    end

    // ---------------- divider
    logic [SW-1:0] d_z, d_mag, d_q;
    logic [31:0]   d_cur;
    logic          d_ge, d_big;
    logic [SW-1:0] u_new;

    always_comb begin
        d_z   = (r_state == leso_pkg::O1_DIV) ? r_z2 : r_z3;
        d_mag = d_z[SW-1] ? (~d_z + SW'(1)) : d_z;
        d_cur = {r_rem, r_quo[NUM_W-1]};
        d_ge  = d_cur >= {1'b0, r_b0};
        d_big = (|r_quo[NUM_W-1:SW]) ||
                (d_z[SW-1] ? (r_quo[SW-1:0] > 48'h8000_0000_0000) : r_quo[SW-1]);
        if (d_mag == '0)
            d_q = '0;
        else if (d_big)
            d_q = d_z[SW-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        else
            d_q = d_z[SW-1] ? (~r_quo[SW-1:0] + SW'(1)) : r_quo[SW-1:0];
        u_new = leso_pkg::sat_sum(leso_pkg::SUM_W'($signed(r_u0)) -
                                  leso_pkg::SUM_W'($signed(d_q)));
    end

    // ---------------- clamp
    logic signed [SW-1:0] ulim_s;
    logic [leso_pkg::SIG_W-1:0] u_clamp;
    logic u_hit;

    always_comb begin
        ulim_s = SW'(r_ulim);
        u_hit  = 1'b1;
        if ($signed(r_u) > ulim_s)       u_clamp = leso_pkg::SIG_W'(ulim_s);
        else if ($signed(r_u) < -ulim_s) u_clamp = leso_pkg::SIG_W'(-ulim_s);
        else begin
            u_clamp = r_u[leso_pkg::SIG_W-1:0];
            u_hit   = 1'b0;
        end
    end

    // ---------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= leso_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_z1        <= '0;
            r_z2        <= '0;
            r_z3        <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;

            if (r_state == leso_pkg::ST_IDLE && i_in_valid) begin
                r_u0 <= i_nominal_u0;
                r_e  <= leso_pkg::sat_sum(leso_pkg::SUM_W'(i_measured_y) -
                                          leso_pkg::SUM_W'($signed(r_z1)));
            end

            if (c_is_mul && !c_done)
                r_prod <= (r_cnt == '0) ? part_sh : r_prod + part_sh;

            if (c_is_div && !c_done) begin
                if (r_cnt == '0) begin
                    r_quo <= {d_mag, FRAC_BITS'(0)};
                    r_rem <= '0;
                end else begin
                    r_rem <= d_ge ? 31'(d_cur - {1'b0, r_b0}) : d_cur[30:0];
                    r_quo <= {r_quo[NUM_W-2:0], d_ge};
                end
            end

            if (c_done) begin
                case (r_state)
                    leso_pkg::O1_B0, leso_pkg::O2_Z1G:
                        r_acc <= leso_pkg::SUM_W'($signed(r_z2)) +
                                 leso_pkg::SUM_W'($signed(m_res));
                    leso_pkg::O2_Z2G:
                        r_acc <= leso_pkg::SUM_W'($signed(r_z3)) +
                                 leso_pkg::SUM_W'($signed(m_res));
                    leso_pkg::O1_G1, leso_pkg::O2_Z2B:
                        r_acc <= r_acc + leso_pkg::SUM_W'($signed(m_res));
                    leso_pkg::O1_G2, leso_pkg::O2_Z3G:
                        r_t <= m_res;
                    leso_pkg::O1_Z1H, leso_pkg::O2_Z1H:
                        r_z1 <= leso_pkg::sat_sum(leso_pkg::SUM_W'($signed(r_z1)) +
                                                  leso_pkg::SUM_W'($signed(m_res)));
                    leso_pkg::O1_Z2H, leso_pkg::O2_Z2H:
                        r_z2 <= leso_pkg::sat_sum(leso_pkg::SUM_W'($signed(r_z2)) +
                                                  leso_pkg::SUM_W'($signed(m_res)));
                    leso_pkg::O2_Z3H:
                        r_z3 <= leso_pkg::sat_sum(leso_pkg::SUM_W'($signed(r_z3)) +
                                                  leso_pkg::SUM_W'($signed(m_res)));
                    leso_pkg::O1_DIV, leso_pkg::O2_DIV:
                        r_u <= u_new;
                    default: ;
                endcase
            end

            // output word: load when the slot is free, drop when taken
            if (r_state == leso_pkg::ST_FIN && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
                o_control_u <= u_clamp;
                o_clamped   <= u_hit;
                o_est_z1    <= r_z1;
                o_est_z2    <= r_z2;
                o_est_z3    <= (r_order == leso_pkg::ORDER_ONE) ? '0 : r_z3;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- checks
    `LESO_ASSERT_NEXT(a_accept_starts, (i_in_valid && !o_in_stall),
        (r_state != leso_pkg::ST_IDLE), "accepted sample did not start the sequencer")
    `LESO_ASSERT_NOW(a_cnt_bound, 1'b1, (r_cnt <= DIV_LAST), "step counter out of range")
    `LESO_ASSERT_NOW(a_out_from_fin, $rose(o_out_valid),
        ($past(r_state) == leso_pkg::ST_FIN), "output word loaded outside finish step")

endmodule

[verif/leso_scoreboard.sv]
// Self-checking monitor for the observer unit: follows the config, input and output
// channels, predicts each result word and compares. Depends on leso_pkg.
`timescale 1ns / 1ps

module leso_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [leso_pkg::SIG_W-1:0] i_measured_y,
    input  logic signed [leso_pkg::SIG_W-1:0] i_nominal_u0,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [leso_pkg::SIG_W-1:0] i_control_u,
    input  logic signed [leso_pkg::ST_W-1:0]  i_est_z1,
    input  logic signed [leso_pkg::ST_W-1:0]  i_est_z2,
    input  logic signed [leso_pkg::ST_W-1:0]  i_est_z3,
    input  logic                              i_clamped,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [leso_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [leso_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int FRAC = 16;
    localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MIN48 = -64'sh0000_8000_0000_0000;

    typedef struct {
        logic [leso_pkg::SIG_W-1:0] control_u;
        logic [leso_pkg::ST_W-1:0]  z1;
        logic [leso_pkg::ST_W-1:0]  z2;
        logic [leso_pkg::ST_W-1:0]  z3;
        logic                       clamped;
    } t_obs_word;

    t_obs_word expected_words[$];

    logic [1:0] order_q;
    longint     h_q, b0_q, beta1_q, beta2_q, beta3_q, ulim_q;
    longint     z1_q, z2_q, z3_q;

    function automatic longint sat48(longint v);
        if (v > MAX48) return MAX48;
        if (v < MIN48) return MIN48;
        return v;
    endfunction

    // |a*b| >> sh, sign of a, saturated to 48 bits
    function automatic longint scale_q(longint a, longint b, int sh);
        logic [127:0] p;
        logic [127:0] lim;
        logic [63:0]  mag;
        mag = (a < 0) ? -a : a;
        p   = (128'(mag) * 128'(b[63:0])) >> sh;
        lim = (a < 0) ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (p > lim) p = lim;
        return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint divide_b0(longint z, longint den);
        logic [127:0] p;
        logic [127:0] lim;
        logic [63:0]  mag;
        if (den == 0) return (z == 0) ? 0 : ((z < 0) ? MIN48 : MAX48);
        mag = (z < 0) ? -z : z;
        p   = (128'(mag) << FRAC) / 128'(den[63:0]);
        lim = (z < 0) ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (p > lim) p = lim;
        return (z < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic t_obs_word observe_sample(longint y, longint u0);
        t_obs_word w;
        longint    e, s, u;
        e = sat48(y - z1_q);
        if (order_q == leso_pkg::ORDER_ONE) begin
            s    = sat48(scale_q(u0, b0_q, FRAC) + z2_q + scale_q(e, beta1_q, FRAC));
            z1_q = sat48(z1_q + scale_q(s, h_q, leso_pkg::H_BITS));
            z2_q = sat48(z2_q + scale_q(scale_q(e, beta2_q, FRAC), h_q, leso_pkg::H_BITS));
            u    = sat48(u0 - divide_b0(z2_q, b0_q));
            w.z3 = '0;
        end else begin
            z3_q = sat48(z3_q + scale_q(scale_q(e, beta3_q, FRAC), h_q, leso_pkg::H_BITS));
            u    = sat48(u0 - divide_b0(z3_q, b0_q));
            s    = sat48(z3_q + scale_q(e, beta2_q, FRAC) + scale_q(u, b0_q, FRAC));
            z2_q = sat48(z2_q + scale_q(s, h_q, leso_pkg::H_BITS));
            s    = sat48(z2_q + scale_q(e, beta1_q, FRAC));
            z1_q = sat48(z1_q + scale_q(s, h_q, leso_pkg::H_BITS));
            w.z3 = z3_q[leso_pkg::ST_W-1:0];
        end
        w.clamped = 1'b0;
        if (u > ulim_q) begin
            u = ulim_q;
            w.clamped = 1'b1;
        end
        if (u < -ulim_q) begin
            u = -ulim_q;
            w.clamped = 1'b1;
        end
        w.control_u = u[leso_pkg::SIG_W-1:0];
        w.z1 = z1_q[leso_pkg::ST_W-1:0];
        w.z2 = z2_q[leso_pkg::ST_W-1:0];
        return w;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            if (o_fail_count < 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_obs_word w;
        if (!i_rst_n) begin
            order_q = 2'd2;
            h_q = 16777;
            b0_q = 65536;
            beta1_q = 0;
            beta2_q = 0;
            beta3_q = 0;
            ulim_q = 64'd2147483647;
            z1_q = 0;
            z2_q = 0;
            z3_q = 0;
            o_fail_count = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    leso_pkg::CFG_ORDER: order_q = i_cfg_data[1:0];
                    leso_pkg::CFG_H:     h_q     = longint'(i_cfg_data[23:0]);
                    leso_pkg::CFG_B0:    b0_q    = longint'(i_cfg_data[30:0]);
                    leso_pkg::CFG_BETA1: beta1_q = longint'(i_cfg_data[46:0]);
                    leso_pkg::CFG_BETA2: beta2_q = longint'(i_cfg_data[46:0]);
                    leso_pkg::CFG_BETA3: beta3_q = longint'(i_cfg_data[46:0]);
                    leso_pkg::CFG_ULIM:  ulim_q  = longint'(i_cfg_data[30:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(observe_sample(longint'(i_measured_y),
                                                        longint'(i_nominal_u0)));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result word");
                    o_fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("control_u", 64'(w.control_u),
                                64'(i_control_u[leso_pkg::SIG_W-1:0]));
                    check_field("est_z1", 64'(w.z1), 64'(i_est_z1[leso_pkg::ST_W-1:0]));
                    check_field("est_z2", 64'(w.z2), 64'(i_est_z2[leso_pkg::ST_W-1:0]));
                    check_field("est_z3", 64'(w.z3), 64'(i_est_z3[leso_pkg::ST_W-1:0]));
                    check_field("clamped", 64'(w.clamped), 64'(i_clamped));
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

[verif/linear_extended_state_observer_unit_tb.sv]
// Stimulus and verdict for the observer unit: directed corner samples, then random
// config phases with random samples. Depends on leso_pkg, leso_scoreboard and the DUT.
`timescale 1ns / 1ps

module linear_extended_state_observer_unit_tb;

    localparam int SETTLE_CYCLES = 150;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [leso_pkg::SIG_W-1:0]  i_measured_y;
    logic signed [leso_pkg::SIG_W-1:0]  i_nominal_u0;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic signed [leso_pkg::SIG_W-1:0]  o_control_u;
    logic signed [leso_pkg::ST_W-1:0]   o_est_z1;
    logic signed [leso_pkg::ST_W-1:0]   o_est_z2;
    logic signed [leso_pkg::ST_W-1:0]   o_est_z3;
    logic                               o_clamped;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [leso_pkg::IDX_W-1:0]         i_cfg_index;
    logic [leso_pkg::CFG_W-1:0]         i_cfg_data;
    int                                 fail_count;
    int                                 pending;
    logic                               idle_en;
    int                                 stall_left;

    linear_extended_state_observer_unit i_dut (.*);

    leso_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_measured_y(i_measured_y), .i_nominal_u0(i_nominal_u0),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_control_u(o_control_u), .i_est_z1(o_est_z1), .i_est_z2(o_est_z2),
        .i_est_z3(o_est_z3), .i_clamped(o_clamped),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver stalls in random bursts while idle_en is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (idle_en && stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 4);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [leso_pkg::IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[leso_pkg::CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [leso_pkg::SIG_W-1:0] y,
                               logic [leso_pkg::SIG_W-1:0] u0);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_measured_y <= y;
        i_nominal_u0 <= u0;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drain outstanding words before touching the registers
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [leso_pkg::SIG_W-1:0] pick_signal();
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 3))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return '0;
                   default: return '1;
               endcase
            1, 2: return $urandom;
            default: return leso_pkg::SIG_W'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
        endcase
    endfunction

    function automatic logic [63:0] pick_gain(bit wide);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (wide) return r & 64'h7FFF_FFFF_FFFF;
        return r & 64'h3F_FFFF;
    endfunction

    task automatic random_config(bit extreme);
        write_reg(leso_pkg::CFG_ORDER, $urandom_range(0, 3));
        write_reg(leso_pkg::CFG_H, extreme ? ($urandom_range(0, 1) ? 24'hFF_FFFF : 24'd0)
                                           : $urandom_range(1, 1 << 20));
        write_reg(leso_pkg::CFG_B0, extreme ? ($urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd1)
                                            : $urandom_range(1 << 12, 1 << 20));
        write_reg(leso_pkg::CFG_BETA1, pick_gain(extreme));
        write_reg(leso_pkg::CFG_BETA2, pick_gain(extreme));
        write_reg(leso_pkg::CFG_BETA3, pick_gain(extreme));
        write_reg(leso_pkg::CFG_ULIM, extreme ? ($urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0)
                                              : $urandom_range(1 << 16, 1 << 28));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_measured_y = '0;
        i_nominal_u0 = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_en = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: field extremes
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample('0, '0);
        send_sample('1, '1);
        settle();

        // order 1 with zero gains: z2 holds, so u is u0 less a constant z2/b0 near the clamp limit
        write_reg(leso_pkg::CFG_ORDER, leso_pkg::ORDER_ONE);
        write_reg(leso_pkg::CFG_H, 24'hFF_FFFF);
        write_reg(leso_pkg::CFG_B0, 32'd65536);
        write_reg(leso_pkg::CFG_BETA1, '0);
        write_reg(leso_pkg::CFG_BETA2, '0);
        write_reg(leso_pkg::CFG_BETA3, 64'h7FFF_FFFF_FFFF);
        write_reg(leso_pkg::CFG_ULIM, 32'd1000);
        send_sample(32'd5, 32'd1000);
        send_sample(32'd5, -32'sd1000);
        send_sample(32'd5, 32'd1001);
        send_sample(32'd5, -32'sd1001);
        settle();

        // zero b0 in order 2 with big beta3: quotient saturates
        write_reg(leso_pkg::CFG_ORDER, 2'd2);
        write_reg(leso_pkg::CFG_B0, '0);
        write_reg(leso_pkg::CFG_ULIM, 32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'd0);
        send_sample(32'h8000_0000, 32'd7);
        send_sample(32'd0, 32'd0);
        settle();

        // order codes 0 and 3 behave as order 2; saturating gains
        write_reg(leso_pkg::CFG_B0, 32'h7FFF_FFFF);
        write_reg(leso_pkg::CFG_BETA1, 64'h7FFF_FFFF_FFFF);
        write_reg(leso_pkg::CFG_BETA2, 64'h7FFF_FFFF_FFFF);
        write_reg(leso_pkg::CFG_ORDER, 2'd0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000);
        settle();
        write_reg(leso_pkg::CFG_ORDER, 2'd3);
        write_reg(leso_pkg::CFG_ULIM, '0);
        send_sample(32'h1234_5678, 32'h8765_4321);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            random_config(ph % 4 == 3);
            if (ph == 9) idle_en = 1'b0;
            repeat (124) send_sample(pick_signal(), pick_signal());
            settle();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
